// File: rtl/sbva_pkg.sv
// ----------------------------------------------------------------------------
// Sparse byte vector accumulator package
// Shared widths, operation and status codes, and the command and lookup
// structures passed between the controller and the row of storage cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbva_pkg;

  localparam int CAPACITY    = 64;
  localparam int INDEX_WIDTH = 16;

  localparam int OP_W   = 3;
  localparam int VAL_W  = 8;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;
  localparam int LEN_W  = 17;

  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (INDEX_WIDTH > LEN_W) ? INDEX_WIDTH : LEN_W;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(65536);

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_ADD    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic                   write;
    logic                   shift;
    logic [SLOT_W-1:0]      slot;
    logic [INDEX_WIDTH-1:0] idx;
    logic [VAL_W-1:0]       val;
    logic [CNT_W-1:0]       count;
  } cell_cmd_t;

  // Lookup result gathered from the row.
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  old;
  } look_t;

endpackage

`default_nettype wire

// File: rtl/sbva_if.sv
// ----------------------------------------------------------------------------
// Sparse byte vector accumulator channels
// Valid/ready interfaces for the request, response and configuration
// channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sbva_req_if;
  logic                            valid;
  logic                            ready;
  logic [sbva_pkg::OP_W-1:0]       operation;
  logic [sbva_pkg::INDEX_WIDTH-1:0] index;
  logic [sbva_pkg::VAL_W-1:0]      value;

  modport source (output valid, output operation, output index, output value, input ready);
  modport sink   (input valid, input operation, input index, input value, output ready);
endinterface

interface sbva_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [sbva_pkg::VAL_W-1:0]  read_value;
  logic                        present;
  logic [sbva_pkg::STAT_W-1:0] status;
  logic [sbva_pkg::OCC_W-1:0]  occupancy;

  modport source (output valid, output read_value, output present, output status,
                  output occupancy, input ready);
  modport sink   (input valid, input read_value, input present, input status,
                  input occupancy, output ready);
endinterface

interface sbva_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [sbva_pkg::LEN_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/sbva_cell.sv
// ----------------------------------------------------------------------------
// Sparse byte vector storage cell
// Holds one (index, value) pair, compares it against the lookup key and
// either loads new data or takes its upper neighbor's pair on a compaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbva_cell (
  input  wire logic                             clk_i,
  input  wire sbva_pkg::cell_cmd_t              cmd_i,
  input  wire logic [sbva_pkg::SLOT_W-1:0]      cell_id_i,
  input  wire logic [sbva_pkg::INDEX_WIDTH-1:0] key_i,
  input  wire logic [sbva_pkg::INDEX_WIDTH-1:0] next_idx_i,
  input  wire logic [sbva_pkg::VAL_W-1:0]       next_val_i,
  output logic                                  match_o,
  output logic [sbva_pkg::INDEX_WIDTH-1:0]      idx_o,
  output logic [sbva_pkg::VAL_W-1:0]            val_o
);

  logic [sbva_pkg::INDEX_WIDTH-1:0] idx_q;
  logic [sbva_pkg::VAL_W-1:0]       val_q;
  logic                             active;

  // A cell is in use when its position lies below the fill count.
  assign active  = sbva_pkg::CNT_W'(cell_id_i) < cmd_i.count;
  assign match_o = active && (idx_q == key_i);
  assign idx_o   = idx_q;
  assign val_o   = val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && (cmd_i.slot == cell_id_i)) begin
      idx_q <= cmd_i.idx;
      val_q <= cmd_i.val;
    end else if (cmd_i.shift && (cell_id_i >= cmd_i.slot)) begin
      idx_q <= next_idx_i;
      val_q <= next_val_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sbva_cell_row.sv
// ----------------------------------------------------------------------------
// Sparse byte vector cell row
// Chains the storage cells so that each can take its neighbor's pair, and
// gathers hit, slot and stored value for the lookup key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbva_cell_row (
  input  wire logic                             clk_i,
  input  wire sbva_pkg::cell_cmd_t              cmd_i,
  input  wire logic [sbva_pkg::INDEX_WIDTH-1:0] key_i,
  output sbva_pkg::look_t                       look_o
);

  logic [sbva_pkg::INDEX_WIDTH-1:0] idx_w   [sbva_pkg::CAPACITY];
  logic [sbva_pkg::VAL_W-1:0]       val_w   [sbva_pkg::CAPACITY];
  logic [sbva_pkg::CAPACITY-1:0]    match_w;

  for (genvar g = 0; g < sbva_pkg::CAPACITY; g++) begin : g_cell
    logic [sbva_pkg::INDEX_WIDTH-1:0] next_idx;
    logic [sbva_pkg::VAL_W-1:0]       next_val;

    if (g == sbva_pkg::CAPACITY - 1) begin : g_last
      assign next_idx = idx_w[g];
      assign next_val = val_w[g];
    end else begin : g_mid
      assign next_idx = idx_w[g+1];
      assign next_val = val_w[g+1];
    end

    sbva_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd_i),
      .cell_id_i  (sbva_pkg::SLOT_W'(g)),
      .key_i      (key_i),
      .next_idx_i (next_idx),
      .next_val_i (next_val),
      .match_o    (match_w[g]),
      .idx_o      (idx_w[g]),
      .val_o      (val_w[g])
    );
  end

  // Stored indices are unique, so at most one cell matches and an OR
  // reduction selects its slot and value.
  always_comb begin
    look_o.hit  = |match_w;
    look_o.slot = '0;
    look_o.old  = '0;
    for (int i = 0; i < sbva_pkg::CAPACITY; i++) begin
      if (match_w[i]) begin
        look_o.slot = look_o.slot | sbva_pkg::SLOT_W'(i);
        look_o.old  = look_o.old | val_w[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/sparse_byte_vector_accumulator.sv
// ----------------------------------------------------------------------------
// Sparse byte vector accumulator
// Associative store of up to CAPACITY (index, byte) pairs with read, write,
// add, remove and clear operations on a valid/ready request channel.
// ----------------------------------------------------------------------------
// The cell row looks up a request at its transfer; the update that depends on
//   it follows in the update state and registers the result. A new request is
//   taken only in the idle state, after the last one has been applied.
// A pending response does not block the next request transfer; only the
//   update cycle waits for the output register to free up.
// Reset: asynchronous, active low; the store is empty and vector_length is
//   65536. The cell contents are not cleared, the fill count masks them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sparse_byte_vector_accumulator (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sbva_req_if.sink   req_i,
  sbva_rsp_if.source rsp_o,
  sbva_cfg_if.sink   cfg_i
);

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_e;

  state_e state_q;

  // Configuration register. The user must write it only while the block is idle; the block does not enforce this.
  logic [sbva_pkg::LEN_W-1:0] vlen_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q <= sbva_pkg::LEN_RESET;
    end else if (cfg_i.valid) begin
      vlen_q <= cfg_i.data;
    end
  end

  // Fill count: slots below it hold live pairs.
  logic [sbva_pkg::CNT_W-1:0] count_q;
  logic [sbva_pkg::CNT_W-1:0] count_d;

  // Request accepted in the idle state; the cell row looks up the incoming
  // index in the same cycle and the outcome is captured with the request.
  logic req_xfer;
  assign req_i.ready = (state_q == S_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;

  sbva_pkg::cell_cmd_t cmd;
  sbva_pkg::look_t     look;

  sbva_cell_row u_row (
    .clk_i  (clk_i),
    .cmd_i  (cmd),
    .key_i  (req_i.index),
    .look_o (look)
  );

  logic [sbva_pkg::OP_W-1:0]        op_q;
  logic [sbva_pkg::INDEX_WIDTH-1:0] idx_q;
  logic [sbva_pkg::VAL_W-1:0]       val_q;
  logic                             oor_q;
  sbva_pkg::look_t                  look_q;
  logic                             oor;

  assign oor = sbva_pkg::CMP_W'(req_i.index) >= sbva_pkg::CMP_W'(vlen_q);

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      op_q   <= req_i.operation;
      idx_q  <= req_i.index;
      val_q  <= req_i.value;
      oor_q  <= oor;
      look_q <= look;
    end
  end

  // The update cycle completes once the output register can take a result.
  logic fire;
  assign fire = (state_q == S_APPLY) && (!rsp_o.valid || rsp_o.ready);

  logic [sbva_pkg::VAL_W-1:0]  sum;
  logic [sbva_pkg::VAL_W-1:0]  newv;
  logic [sbva_pkg::VAL_W-1:0]  rv_d;
  logic                        pr_d;
  logic [sbva_pkg::STAT_W-1:0] st_d;
  logic                        wr;
  logic                        sh;
  logic [sbva_pkg::SLOT_W-1:0] slot;

  // An absent index looks up as zero, so an add to it just stores the value.
  assign sum  = look_q.old + val_q;
  assign newv = (op_q == sbva_pkg::OP_ADD) ? sum : val_q;

  always_comb begin
    count_d = count_q;
    rv_d    = '0;
    pr_d    = 1'b0;
    st_d    = sbva_pkg::ST_OK;
    wr      = 1'b0;
    sh      = 1'b0;
    slot    = look_q.slot;
    priority if (op_q == sbva_pkg::OP_CLEAR) begin
      count_d = '0;
    end else if (oor_q) begin
      st_d = sbva_pkg::ST_RANGE;
    end else if ((op_q == sbva_pkg::OP_WRITE) || (op_q == sbva_pkg::OP_ADD)) begin
      priority if (newv == '0) begin
        // A zero value removes the pair: the cells above it move down one.
        if (look_q.hit) begin
          sh      = 1'b1;
          count_d = count_q - 1'b1;
        end
      end else if (look_q.hit) begin
        wr   = 1'b1;
        rv_d = newv;
        pr_d = 1'b1;
      end else if (count_q == sbva_pkg::CNT_W'(sbva_pkg::CAPACITY)) begin
        st_d = sbva_pkg::ST_FULL;
      end else begin
        wr      = 1'b1;
        slot    = sbva_pkg::SLOT_W'(count_q);
        count_d = count_q + 1'b1;
        rv_d    = newv;
        pr_d    = 1'b1;
      end
    end else if (op_q == sbva_pkg::OP_REMOVE) begin
      if (look_q.hit) begin
        sh      = 1'b1;
        count_d = count_q - 1'b1;
      end
    end else begin
      // Read, and the unused codes that behave as a read.
      rv_d = look_q.hit ? look_q.old : '0;
      pr_d = look_q.hit;
    end
  end

  always_comb begin
    cmd.write = fire && wr;
    cmd.shift = fire && sh;
    cmd.slot  = slot;
    cmd.idx   = idx_q;
    cmd.val   = newv;
    cmd.count = count_q;
  end

  // Sequencer, fill count and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      count_q          <= '0;
      rsp_o.valid      <= 1'b0;
      rsp_o.read_value <= '0;
      rsp_o.present    <= 1'b0;
      rsp_o.status     <= sbva_pkg::ST_OK;
      rsp_o.occupancy  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_xfer) begin
            state_q <= S_APPLY;
          end
          if (rsp_o.ready) begin
            rsp_o.valid <= 1'b0;
          end
        end
        S_APPLY: begin
          if (fire) begin
            state_q          <= S_IDLE;
            count_q          <= count_d;
            rsp_o.valid      <= 1'b1;
            rsp_o.read_value <= rv_d;
            rsp_o.present    <= pr_d;
            rsp_o.status     <= st_d;
            rsp_o.occupancy  <= sbva_pkg::OCC_W'(count_d);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sbva_pkg::CNT_W'(sbva_pkg::CAPACITY))
    else $error("fill count above capacity");

  a_occ_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.occupancy == sbva_pkg::OCC_W'(count_q)))
    else $error("pending occupancy differs from fill count");

  a_present_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.present) |-> (rsp_o.read_value != '0))
    else $error("present entry reads as zero");

  a_full_only_at_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == sbva_pkg::ST_FULL)) |->
      (count_q == sbva_pkg::CNT_W'(sbva_pkg::CAPACITY)) && !rsp_o.present)
    else $error("store full status while not full");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> (count_q == $past(count_q)))
    else $error("fill count changed outside the update cycle");
`endif

endmodule

`default_nettype wire
